### rtl/core/assert_macros.svh
// Assertion macros shared by the bank switch mapper RTL.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSIRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BSIRQ_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define BSIRQ_ASSERT(label, clk, rst_n, prop, msg)
`define BSIRQ_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### rtl/core/bsirq_pkg.sv
// Shared types, codes and the result table of the bank switch mapper.
// No dependencies; imported by every module of the block.
package bsirq_pkg;

    localparam int unsigned IN_W  = 40;
    localparam int unsigned OUT_W = 16;

    localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

    localparam logic [7:0][7:0] BANK_RESET =
        {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
    localparam logic [7:0] PRG_SECOND_LAST = 8'd62;
    localparam logic [7:0] PRG_LAST        = 8'd63;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_PRG    = 2'd0;
    localparam kind_t KIND_CHR    = 2'd1;
    localparam kind_t KIND_MIRROR = 2'd2;
    localparam kind_t KIND_IRQ    = 2'd3;

    localparam logic [2:0] SLOT_IRQ_SET = 3'd0;
    localparam logic [2:0] SLOT_IRQ_CLR = 3'd1;

    // {address[15:13], address[0]}
    typedef logic [3:0] reg_sel_t;
    localparam reg_sel_t REG_BANK_SELECT = 4'b1000;
    localparam reg_sel_t REG_BANK_DATA   = 4'b1001;
    localparam reg_sel_t REG_MIRROR      = 4'b1010;
    localparam reg_sel_t REG_PRG_RAM     = 4'b1011;
    localparam reg_sel_t REG_IRQ_LATCH   = 4'b1100;
    localparam reg_sel_t REG_IRQ_RELOAD  = 4'b1101;
    localparam reg_sel_t REG_IRQ_DISABLE = 4'b1110;
    localparam reg_sel_t REG_IRQ_ENABLE  = 4'b1111;

    typedef logic [3:0] step_t;
    localparam step_t STEP_PRG0    = 4'd0;
    localparam step_t STEP_PRG1    = 4'd1;
    localparam step_t STEP_PRG2    = 4'd2;
    localparam step_t STEP_PRG3    = 4'd3;
    localparam step_t STEP_CHR0    = 4'd4;
    localparam step_t STEP_CHR1    = 4'd5;
    localparam step_t STEP_CHR2    = 4'd6;
    localparam step_t STEP_CHR3    = 4'd7;
    localparam step_t STEP_CHR4    = 4'd8;
    localparam step_t STEP_CHR5    = 4'd9;
    localparam step_t STEP_CHR6    = 4'd10;
    localparam step_t STEP_CHR7    = 4'd11;
    localparam step_t STEP_MIRROR  = 4'd12;
    localparam step_t STEP_IRQ_SET = 4'd13;
    localparam step_t STEP_IRQ_CLR = 4'd14;

    localparam logic CFG_FOUR_SCREEN = 1'b0;
    localparam logic CFG_REV_B       = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic commit;
        logic load_step;
        logic advance;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic has_result;
        logic step_last;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic four_screen;
        logic rev_b;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] slot;
        logic [7:0] bank;
    } result_t;

    function automatic result_t gen_result(
        input step_t           step,
        input logic [7:0]      cmd,
        input logic [7:0][7:0] banks,
        input logic [7:0]      data
    );
        result_t    r;
        logic [2:0] x;
        logic [2:0] k;
        r = '0;
        x = {cmd[7], 2'b00};
        k = 3'(step - STEP_CHR0);
        case (step)
            STEP_PRG0:
            begin
                r.kind = KIND_PRG;
                r.slot = cmd[6] ? 3'd2 : 3'd0;
                r.bank = {2'b00, banks[6][5:0]};
            end
            STEP_PRG1:
            begin
                r.kind = KIND_PRG;
                r.slot = cmd[6] ? 3'd0 : 3'd2;
                r.bank = PRG_SECOND_LAST;
            end
            STEP_PRG2:
            begin
                r.kind = KIND_PRG;
                r.slot = 3'd1;
                r.bank = {2'b00, banks[7][5:0]};
            end
            STEP_PRG3:
            begin
                r.kind = KIND_PRG;
                r.slot = 3'd3;
                r.bank = PRG_LAST;
            end
            STEP_CHR0:
            begin
                r.kind = KIND_CHR;
                r.slot = k ^ x;
                r.bank = {banks[0][7:1], 1'b0};
            end
            STEP_CHR1:
            begin
                r.kind = KIND_CHR;
                r.slot = k ^ x;
                r.bank = {banks[0][7:1], 1'b1};
            end
            STEP_CHR2:
            begin
                r.kind = KIND_CHR;
                r.slot = k ^ x;
                r.bank = {banks[1][7:1], 1'b0};
            end
            STEP_CHR3:
            begin
                r.kind = KIND_CHR;
                r.slot = k ^ x;
                r.bank = {banks[1][7:1], 1'b1};
            end
            STEP_CHR4, STEP_CHR5, STEP_CHR6, STEP_CHR7:
            begin
                r.kind = KIND_CHR;
                r.slot = k ^ x;
                r.bank = banks[3'(k - 3'd2)];
            end
            STEP_MIRROR:
            begin
                r.kind = KIND_MIRROR;
                r.slot = 3'd0;
                r.bank = {7'd0, ~data[0]};
            end
            STEP_IRQ_SET:
            begin
                r.kind = KIND_IRQ;
                r.slot = SLOT_IRQ_SET;
                r.bank = 8'd0;
            end
            STEP_IRQ_CLR:
            begin
                r.kind = KIND_IRQ;
                r.slot = SLOT_IRQ_CLR;
                r.bank = 8'd0;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/bsirq_cfg.sv
// APB configuration registers: four-screen flag and counter revision.
// Depends on bsirq_pkg.
module bsirq_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output bsirq_pkg::cfg_t     cfg
);
    import bsirq_pkg::*;

    logic four_screen_reg;
    logic rev_b_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_screen_reg <= 1'b0;
            rev_b_reg       <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                CFG_FOUR_SCREEN: four_screen_reg <= pwdata[0];
                CFG_REV_B:       rev_b_reg       <= pwdata[0];
                default:         four_screen_reg <= four_screen_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            CFG_FOUR_SCREEN: prdata = {31'd0, four_screen_reg};
            CFG_REV_B:       prdata = {31'd0, rev_b_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.four_screen = four_screen_reg;
    assign cfg.rev_b       = rev_b_reg;

endmodule

### rtl/core/bsirq_ctrl.sv
// Controller: accept, decode/commit, then step out results one at a time.
// Depends on bsirq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsirq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  bsirq_pkg::dp_stat_t stat,
    output bsirq_pkg::dp_cmd_t  cmd
);
    import bsirq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = stat.has_result ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free && stat.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.capture   = s_axis_tvalid;
            end
            ST_DECODE:
            begin
                cmd.commit    = 1'b1;
                cmd.load_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.out_load = stat.out_free;
                cmd.advance  = stat.out_free && !stat.step_last;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    `BSIRQ_ASSERT(a_capture_then_decode, clk, rst_n, cmd.capture |=> cmd.commit, "no decode after capture")
    `BSIRQ_ASSERT(a_single_commit, clk, rst_n, cmd.commit |=> !cmd.commit, "item committed twice")

endmodule

### rtl/core/bsirq_dp.sv
// Datapath: item capture, mapper state, result plan, step counter, output register.
// Depends on bsirq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsirq_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  bsirq_pkg::cfg_t     cfg,
    input  bsirq_pkg::dp_cmd_t  cmd,
    output bsirq_pkg::dp_stat_t stat,
    input  logic [bsirq_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [bsirq_pkg::OUT_W-1:0] m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);
    import bsirq_pkg::*;

    // captured item
    logic       func_reg;
    reg_sel_t   sel_reg;
    logic [7:0] data_reg;
    logic [8:0] line_reg;
    logic       disp_reg;

    // mapper state
    logic [7:0]      cmd_reg;
    logic [7:0][7:0] banks_reg;
    logic [7:0]      latch_reg;
    logic [7:0]      counter_reg;
    logic            reload_reg;
    logic            enable_reg;

    step_t step_reg;
    step_t end_reg;

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    out_last_reg;

    logic       visible;
    logic       cnt_zero;
    logic [7:0] cnt_new;
    logic       fire;
    logic       prg_chg;
    logic       chr_chg;
    logic       plan_has;
    step_t      plan_first;
    step_t      plan_last;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= s_axis_tuser;
            sel_reg  <= {s_axis_tdata[15:13], s_axis_tdata[0]};
            data_reg <= s_axis_tdata[23:16];
            line_reg <= s_axis_tdata[32:24];
            disp_reg <= s_axis_tdata[33];
        end
    end

    assign visible  = (line_reg <= LAST_VISIBLE_LINE) && disp_reg;
    assign cnt_zero = (counter_reg == 8'd0);
    assign cnt_new  = (cnt_zero || reload_reg) ? latch_reg : counter_reg - 8'd1;
    assign fire     = (!cnt_zero || cfg.rev_b) && (cnt_new == 8'd0) && enable_reg;
    assign prg_chg  = data_reg[6] ^ cmd_reg[6];
    assign chr_chg  = data_reg[7] ^ cmd_reg[7];

    always_comb
    begin
        plan_has   = 1'b0;
        plan_first = STEP_PRG0;
        plan_last  = STEP_PRG0;
        if (func_reg)
        begin
            plan_has   = visible && fire;
            plan_first = STEP_IRQ_SET;
            plan_last  = STEP_IRQ_SET;
        end
        else
        begin
            case (sel_reg)
                REG_BANK_SELECT:
                begin
                    plan_has   = prg_chg || chr_chg;
                    plan_first = prg_chg ? STEP_PRG0 : STEP_CHR0;
                    plan_last  = chr_chg ? STEP_CHR7 : STEP_PRG3;
                end
                REG_BANK_DATA:
                begin
                    plan_has = 1'b1;
                    case (cmd_reg[2:0])
                        3'd0:
                        begin
                            plan_first = STEP_CHR0;
                            plan_last  = STEP_CHR1;
                        end
                        3'd1:
                        begin
                            plan_first = STEP_CHR2;
                            plan_last  = STEP_CHR3;
                        end
                        3'd2:
                        begin
                            plan_first = STEP_CHR4;
                            plan_last  = STEP_CHR4;
                        end
                        3'd3:
                        begin
                            plan_first = STEP_CHR5;
                            plan_last  = STEP_CHR5;
                        end
                        3'd4:
                        begin
                            plan_first = STEP_CHR6;
                            plan_last  = STEP_CHR6;
                        end
                        3'd5:
                        begin
                            plan_first = STEP_CHR7;
                            plan_last  = STEP_CHR7;
                        end
                        3'd6:
                        begin
                            plan_first = STEP_PRG0;
                            plan_last  = STEP_PRG0;
                        end
                        default:
                        begin
                            plan_first = STEP_PRG2;
                            plan_last  = STEP_PRG2;
                        end
                    endcase
                end
                REG_MIRROR:
                begin
                    plan_has   = !cfg.four_screen;
                    plan_first = STEP_MIRROR;
                    plan_last  = STEP_MIRROR;
                end
                REG_IRQ_DISABLE:
                begin
                    plan_has   = 1'b1;
                    plan_first = STEP_IRQ_CLR;
                    plan_last  = STEP_IRQ_CLR;
                end
                default:
                begin
                    plan_has = 1'b0;
                end
            endcase
        end
    end

    // any write outside the decoded registers lands on the enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= 8'd0;
            banks_reg   <= BANK_RESET;
            latch_reg   <= 8'd0;
            counter_reg <= 8'd0;
            reload_reg  <= 1'b0;
            enable_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            if (func_reg)
            begin
                if (visible)
                begin
                    counter_reg <= cnt_new;
                    reload_reg  <= 1'b0;
                end
            end
            else
            begin
                case (sel_reg)
                    REG_BANK_SELECT: cmd_reg                  <= data_reg;
                    REG_BANK_DATA:   banks_reg[cmd_reg[2:0]]  <= data_reg;
                    REG_MIRROR:      enable_reg               <= enable_reg;
                    REG_PRG_RAM:     enable_reg               <= enable_reg;
                    REG_IRQ_LATCH:   latch_reg                <= data_reg;
                    REG_IRQ_RELOAD:  reload_reg               <= 1'b1;
                    REG_IRQ_DISABLE: enable_reg               <= 1'b0;
                    REG_IRQ_ENABLE:  enable_reg               <= 1'b1;
                    default:         enable_reg               <= 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            step_reg <= plan_first;
            end_reg  <= plan_last;
        end
        else if (cmd.advance)
        begin
            step_reg <= step_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_res_reg  <= gen_result(step_reg, cmd_reg, banks_reg, data_reg);
            out_last_reg <= (step_reg == end_reg);
        end
    end

    assign stat.has_result = plan_has;
    assign stat.step_last  = (step_reg == end_reg);
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.bank, out_res_reg.slot};
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_last_reg;

    `BSIRQ_ASSERT(a_step_in_plan, clk, rst_n, cmd.out_load |-> (step_reg <= end_reg), "step ran past plan end")
    `BSIRQ_NEVER(a_no_overwrite, clk, rst_n, cmd.out_load && out_valid_reg && !m_axis_tready, "pending result overwritten")
    `BSIRQ_ASSERT(a_enable_by_commit, clk, rst_n, $rose(enable_reg) |-> $past(cmd.commit), "irq enable set outside commit")

endmodule

### rtl/core/bank_switch_scanline_irq_mapper.sv
// Top level of the bank switch mapper with scanline IRQ counter.
// Depends on bsirq_pkg, bsirq_cfg, bsirq_ctrl and bsirq_dp.
//
//   channel   | direction | payload
//   ----------+-----------+-----------------------------------------------
//   s_axis    | in        | tuser: func; tdata: address, data, scanline,
//             |           |   display_on
//   m_axis    | out       | tuser: kind; tdata: slot, bank; tlast: last
//   apb       | in/out    | reg 0 four_screen @0x0, reg 1 rev_b @0x4
//
// An item passes through accept, then decode and commit, then one emit step per
// result it causes; the result sequencer emits one result per cycle, while
// m_axis accepts, from a single output register.
// The next item is accepted while the final result still waits in that register.
// A stalled m_axis holds the sequencer; reset restores the bank registers and
// leaves no result pending.
module bank_switch_scanline_irq_mapper (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [15:0] address, [23:16] data, [32:24] scanline, [33] display_on
    input  logic [bsirq_pkg::IN_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] slot, [10:3] bank
    output logic [bsirq_pkg::OUT_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bsirq_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    bsirq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bsirq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bsirq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### dv/bank_switch_scanline_irq_mapper_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bank_switch_scanline_irq_mapper: directed and random
// CPU writes and scanline ticks on the input stream, with slot mappings predicted here.
// Depends on bsirq_pkg and the mapper RTL; register settings are changed over APB.
module bank_switch_scanline_irq_mapper_test;
    import bsirq_pkg::*;

    localparam logic [2:0] ADDR_FOUR_SCREEN = 3'd0;
    localparam logic [2:0] ADDR_REV_B       = 3'd4;

    localparam logic [2:0] BANK_CHR_PAIR_LO = 3'd0;
    localparam logic [2:0] BANK_CHR_PAIR_HI = 3'd1;
    localparam logic [2:0] BANK_PRG_SWAP    = 3'd6;
    localparam logic [2:0] BANK_PRG_MID     = 3'd7;

    localparam int PRG_MODE_BIT  = 6;
    localparam int CHR_MODE_BIT  = 7;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 65;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] slot;
        logic [7:0] bank;
        logic       last;
    } mapping_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0] bank_reg [0:7];
    logic [7:0] bank_cmd;
    logic [7:0] irq_latch_val;
    logic [7:0] irq_count;
    logic       irq_reload_req;
    logic       irq_on;
    logic [7:0] ram_protect;
    logic       cfg_four_screen;
    logic       cfg_rev_b;

    mapping_t expected_mappings [$];
    mapping_t pend [0:11];
    int       pend_n;

    int errors;
    int items_sent;
    int items_counted;
    int results_checked;
    int hold_request;
    bit tx_steady;
    bit rx_steady;

    bank_switch_scanline_irq_mapper dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic add_mapping(input kind_t kind, input logic [2:0] slot,
                               input logic [7:0] bank);
        pend[pend_n] = '{kind: kind, slot: slot, bank: bank, last: 1'b0};
        pend_n++;
    endtask

    task automatic predict_mappings(input logic func, input logic [15:0] addr,
                                    input logic [7:0] data, input logic [8:0] line,
                                    input logic disp);
        reg_sel_t   sel;
        logic [2:0] flip;
        logic [2:0] idx;
        logic [7:0] prior;
        logic [7:0] b;
        mapping_t   m;
        pend_n = 0;
        if (!func)
        begin
            flip = bank_cmd[CHR_MODE_BIT] ? 3'd4 : 3'd0;
            idx  = bank_cmd[2:0];
            sel  = {addr[15:13], addr[0]};
            case (sel)
                REG_BANK_SELECT:
                begin
                    if (data[PRG_MODE_BIT] != bank_cmd[PRG_MODE_BIT])
                    begin
                        b = {2'b00, bank_reg[BANK_PRG_SWAP][5:0]};
                        add_mapping(KIND_PRG, data[PRG_MODE_BIT] ? 3'd2 : 3'd0, b);
                        add_mapping(KIND_PRG, data[PRG_MODE_BIT] ? 3'd0 : 3'd2,
                                    PRG_SECOND_LAST);
                        add_mapping(KIND_PRG, 3'd1, {2'b00, bank_reg[BANK_PRG_MID][5:0]});
                        add_mapping(KIND_PRG, 3'd3, PRG_LAST);
                    end
                    if (data[CHR_MODE_BIT] != bank_cmd[CHR_MODE_BIT])
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            if (k < 2)
                                b = {bank_reg[BANK_CHR_PAIR_LO][7:1], k[0]};
                            else if (k < 4)
                                b = {bank_reg[BANK_CHR_PAIR_HI][7:1], k[0]};
                            else
                                b = bank_reg[k - 2];
                            add_mapping(KIND_CHR, 3'(k) ^ (data[CHR_MODE_BIT] ? 3'd4 : 3'd0),
                                        b);
                        end
                    end
                    bank_cmd = data;
                end
                REG_BANK_DATA:
                begin
                    bank_reg[idx] = data;
                    case (idx)
                        BANK_CHR_PAIR_LO:
                        begin
                            add_mapping(KIND_CHR, 3'd0 ^ flip, {data[7:1], 1'b0});
                            add_mapping(KIND_CHR, 3'd1 ^ flip, {data[7:1], 1'b1});
                        end
                        BANK_CHR_PAIR_HI:
                        begin
                            add_mapping(KIND_CHR, 3'd2 ^ flip, {data[7:1], 1'b0});
                            add_mapping(KIND_CHR, 3'd3 ^ flip, {data[7:1], 1'b1});
                        end
                        BANK_PRG_SWAP:
                            add_mapping(KIND_PRG, bank_cmd[PRG_MODE_BIT] ? 3'd2 : 3'd0,
                                        {2'b00, data[5:0]});
                        BANK_PRG_MID:
                            add_mapping(KIND_PRG, 3'd1, {2'b00, data[5:0]});
                        default:
                            add_mapping(KIND_CHR, (idx + 3'd2) ^ flip, data);
                    endcase
                end
                REG_MIRROR:
                    if (!cfg_four_screen)
                        add_mapping(KIND_MIRROR, 3'd0, {7'd0, ~data[0]});
                REG_PRG_RAM:
                    ram_protect = data;
                REG_IRQ_LATCH:
                    irq_latch_val = data;
                REG_IRQ_RELOAD:
                    irq_reload_req = 1'b1;
                REG_IRQ_DISABLE:
                begin
                    irq_on = 1'b0;
                    add_mapping(KIND_IRQ, SLOT_IRQ_CLR, 8'd0);
                end
                default:
                    irq_on = 1'b1;
            endcase
        end
        else if (line <= LAST_VISIBLE_LINE && disp)
        begin
            prior = irq_count;
            if (prior == 8'd0 || irq_reload_req)
            begin
                irq_count      = irq_latch_val;
                irq_reload_req = 1'b0;
            end
            else
                irq_count = prior - 8'd1;
            if ((prior != 8'd0 || cfg_rev_b) && irq_count == 8'd0 && irq_on)
                add_mapping(KIND_IRQ, SLOT_IRQ_SET, 8'd0);
        end
        for (int i = 0; i < pend_n; i++)
        begin
            m      = pend[i];
            m.last = (i == pend_n - 1);
            expected_mappings.push_back(m);
        end
    endtask

    task automatic send_item(input logic func, input logic [15:0] addr,
                             input logic [7:0] data, input logic [8:0] line,
                             input logic disp);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        predict_mappings(func, addr, data, line, disp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, disp, line, data, addr};
        s_axis_tuser  <= func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (!func || (line <= LAST_VISIBLE_LINE && disp))
            items_counted++;
    endtask

    task automatic write_reg(input reg_sel_t sel, input logic [7:0] data);
        send_item(1'b0, {sel[3:1], 12'($urandom), sel[0]}, data,
                  9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    task automatic tick_line(input logic [8:0] line, input logic disp);
        send_item(1'b1, 16'h8000 | 16'($urandom), 8'($urandom), line, disp);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_mappings.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic four_screen, input logic rev_b);
        wait_idle();
        apb_write(ADDR_FOUR_SCREEN, {31'd0, four_screen});
        cfg_four_screen = four_screen;
        apb_write(ADDR_REV_B, {31'd0, rev_b});
        cfg_rev_b = rev_b;
    endtask

    task automatic test_bank_modes();
        send_item(1'b0, 16'h8000, 8'hC0, 9'd261, 1'b1);
        write_reg(REG_BANK_SELECT, 8'h40);
        write_reg(REG_BANK_SELECT, 8'h00);
    endtask

    task automatic test_bank_registers();
        for (int r = 0; r < 8; r++)
        begin
            write_reg(REG_BANK_SELECT, (r[0] ? 8'hC0 : 8'h00) | 8'(r));
            write_reg(REG_BANK_DATA, r[1] ? 8'h00 : 8'hFF);
        end
    endtask

    task automatic test_mirroring();
        write_reg(REG_MIRROR, 8'h00);
        write_reg(REG_MIRROR, 8'hFF);
    endtask

    task automatic test_irq_counter();
        write_reg(REG_IRQ_LATCH, 8'd1);
        write_reg(REG_IRQ_RELOAD, 8'h00);
        send_item(1'b0, 16'hFFFF, 8'hFF, 9'd0, 1'b0);
        tick_line(9'd0, 1'b1);
        tick_line(LAST_VISIBLE_LINE, 1'b1);
        tick_line(9'd261, 1'b1);
        tick_line(9'd100, 1'b0);
        write_reg(REG_IRQ_DISABLE, 8'h00);
    endtask

    task automatic random_sequence();
        int       pick;
        int       ticks;
        int       line;
        bit       disp;
        reg_sel_t sel;
        pick      = $urandom_range(0, 99);
        tx_steady = ($urandom_range(0, 4) == 0);
        rx_steady = ($urandom_range(0, 5) == 0);
        if (pick < 35)
        begin
            write_reg(REG_BANK_SELECT, 8'($urandom));
            repeat ($urandom_range(1, 3)) write_reg(REG_BANK_DATA, 8'($urandom));
        end
        else if (pick < 65)
        begin
            write_reg(REG_IRQ_LATCH, ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 6)));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IRQ_RELOAD, 8'($urandom));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_IRQ_ENABLE, 8'($urandom));
            ticks = $urandom_range(1, 12);
            repeat (ticks)
            begin
                line = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 261)
                                                   : $urandom_range(0, 239);
                disp = ($urandom_range(0, 9) != 0);
                tick_line(9'(line), disp);
            end
        end
        else if (pick < 75)
            write_reg(REG_MIRROR, 8'($urandom));
        else if (pick < 85)
        begin
            sel = {1'b1, 3'($urandom)};
            write_reg(sel, 8'($urandom));
        end
        else
            send_item(1'($urandom), 16'h8000 | 16'($urandom), 8'($urandom),
                      9'($urandom_range(0, 261)), 1'($urandom));
    endtask

    task automatic test_random_traffic(input logic four_screen, input logic rev_b);
        int target;
        set_registers(four_screen, rev_b);
        target = items_counted + PHASE_ITEMS;
        while (items_counted < target)
            random_sequence();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_output_hold_off();
        wait_idle();
        hold_request = HOLD_CYCLES;
        tx_steady    = 1'b1;
        for (int i = 0; i < 20; i++)
            write_reg(i[0] ? REG_BANK_DATA : REG_BANK_SELECT, 8'($urandom));
        tx_steady = 1'b0;
        wait_idle();
    endtask

    // Receiver: random stalls, steady stretches, and a long hold-off on request.
    initial
    begin
        int hold_cnt;
        int rx_wait;
        hold_cnt      = 0;
        rx_wait       = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_cnt     = hold_request;
                hold_request = 0;
            end
            if (hold_cnt > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt--;
            end
            else if (rx_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_steady)
                    rx_wait = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_mappings
        mapping_t want;
        mapping_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast};
            if (expected_mappings.size() == 0)
            begin
                $display("%0t: unexpected transaction kind %0d slot %0d bank %0d last %0d",
                         $time, got.kind, got.slot, got.bank, got.last);
                errors++;
            end
            else
            begin
                want = expected_mappings.pop_front();
                results_checked++;
                if (got.kind != want.kind)
                begin
                    $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
                    errors++;
                end
                if (got.slot != want.slot)
                begin
                    $display("%0t: slot expected %0d, got %0d", $time, want.slot, got.slot);
                    errors++;
                end
                if (got.bank != want.bank)
                begin
                    $display("%0t: bank expected %0d, got %0d", $time, want.bank, got.bank);
                    errors++;
                end
                if (got.last != want.last)
                begin
                    $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", expected_mappings.size());
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        errors          = 0;
        items_sent      = 0;
        items_counted   = 0;
        results_checked = 0;
        hold_request    = 0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        bank_reg        = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};
        bank_cmd        = 8'd0;
        irq_latch_val   = 8'd0;
        irq_count       = 8'd0;
        irq_reload_req  = 1'b0;
        irq_on          = 1'b0;
        ram_protect     = 8'd0;
        cfg_four_screen = 1'b0;
        cfg_rev_b       = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_bank_modes();
        test_bank_registers();
        test_mirroring();
        test_irq_counter();
        test_random_traffic(1'b1, 1'b0);
        test_random_traffic(1'b0, 1'b0);
        test_output_hold_off();
        test_random_traffic(1'b1, 1'b1);
        test_random_traffic(1'b0, 1'b1);

        wait_idle();
        if (expected_mappings.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_mappings.size());
            errors++;
        end
        $display("Sent %0d items (%0d not ignored), checked %0d mapping results,",
                 items_sent, items_counted, results_checked);
        $display("under all four register settings and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### bank_switch_scanline_irq_mapper.f
+incdir+rtl/core
rtl/core/bsirq_pkg.sv
rtl/core/bsirq_cfg.sv
rtl/core/bsirq_ctrl.sv
rtl/core/bsirq_dp.sv
rtl/core/bank_switch_scanline_irq_mapper.sv
dv/bank_switch_scanline_irq_mapper_test.sv
